>>> rtl/psg_pkg.sv
package psg_pkg;

  localparam logic [1:0] MODE_ADDR = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [3:0] REG_NOISE   = 4'd6;
  localparam logic [3:0] REG_ENABLE  = 4'd7;
  localparam logic [3:0] REG_VOL_A   = 4'd8;
  localparam logic [3:0] REG_ENV_LO  = 4'd11;
  localparam logic [3:0] REG_ENV_HI  = 4'd12;
  localparam logic [3:0] REG_SHAPE   = 4'd13;

  localparam int NUM_CH   = 3;
  localparam int DIV_BITS = 13;

  localparam logic [4:0] ENV_TOP = 5'h1F;

  typedef struct packed {
    logic       wr_en;
    logic       tone_start;
    logic       div_step;
    logic       tone_done;
    logic       ne_step;
    logic       out_load;
    logic [1:0] ch;
  } psg_cmd_t;

  typedef struct packed {
    logic div_needed;
  } psg_stat_t;

endpackage

>>> rtl/psg_three_voice_tone_noise_envelope.sv
// Three-voice sound generator core: tone, noise and envelope.
// Input channel: in_tuser selects the transaction kind (address write,
// data write, tick); in_tdata carries the address or data byte.
// Address and data writes give no result.
// A tick steps the three tone dividers, noise and envelope, and gives one
// result transaction with each channel's gated level and envelope select.
// A tick loads each channel's tone counter in turn; a channel whose counter
// reaches its period runs the restoring divider shared by the channels,
// then noise and envelope step and the result is loaded. No new item is
// taken during a tick; a write following the result is taken right away.
// The result sits in an output register; a new item is accepted while it
// waits, but the next tick holds before loading until the result is taken.
// cfg_wr_en/cfg_wr_data write the noise-zero-as-one bit at any idle time.
// Reset (rst_n low, synchronous) clears registers, counters and output
// valid, not divider or result; noise shift resets to one, envelope step to 31.
module psg_three_voice_tone_noise_envelope (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // value
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  // level_a, env_select_a, level_b, env_select_b, level_c, env_select_c, 6 zero bits
  output logic [23:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  psg_pkg::psg_cmd_t  cmd;
  psg_pkg::psg_stat_t stat;
  logic [17:0]        out_data;

  psg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  psg_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_mode     (in_tuser),
    .in_value    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

  assign out_tdata = {6'd0, out_data};

endmodule

>>> rtl/psg_dp.sv
module psg_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  psg_pkg::psg_cmd_t  cmd,
  output psg_pkg::psg_stat_t stat,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_value,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output logic [17:0]        out_data
);

  logic [7:0]  regs_r [16];
  logic        addr_valid_r;
  logic [3:0]  sel_idx_r;
  logic [11:0] tcnt_r [psg_pkg::NUM_CH];
  logic [4:0]  tphase_r [psg_pkg::NUM_CH];
  logic [4:0]  ncnt_r;
  logic        npre_r;
  logic [16:0] nshift_r;
  logic [15:0] ecnt_r;
  logic [4:0]  estep_r;
  logic        eattack_r;
  logic        ehold_r;
  logic        ealt_r;
  logic        eholding_r;
  logic        nz1_r;
  logic [12:0] dvd_r;
  logic [11:0] rem_r;
  logic [4:0]  quo_r;
  logic [17:0] out_r;

  logic [11:0] period;
  logic [12:0] c_inc;
  logic [12:0] r2;
  logic        ge;
  logic [4:0]  nper;
  logic [5:0]  nc;
  logic [15:0] eper;
  logic [16:0] ec;
  logic [4:0]  env_vol;
  logic [17:0] out_nxt;
  logic [3:0]  per_idx;

  always_comb begin
    per_idx = {1'b0, cmd.ch, 1'b0};
    period  = {regs_r[per_idx + 4'd1][3:0], regs_r[per_idx]};
    if (period == 12'd0) begin
      period = 12'd1;
    end
    c_inc = {1'b0, tcnt_r[cmd.ch]} + 13'd1;
    stat.div_needed = (c_inc >= {1'b0, period});
    r2 = {rem_r, dvd_r[12]};
    ge = (r2 >= {1'b0, period});
    nper = regs_r[psg_pkg::REG_NOISE][4:0];
    if (nz1_r && nper == 5'd0) begin
      nper = 5'd1;
    end
    nc = {1'b0, ncnt_r} + 6'd1;
    eper = {regs_r[psg_pkg::REG_ENV_HI], regs_r[psg_pkg::REG_ENV_LO]};
    ec = {1'b0, ecnt_r} + 17'd1;
    env_vol = estep_r ^ {5{eattack_r}};
    for (int i = 0; i < psg_pkg::NUM_CH; i++) begin
      logic [7:0] vol;
      logic       gate;
      vol  = regs_r[psg_pkg::REG_VOL_A + 4'(i)];
      gate = (tphase_r[i][0] | regs_r[psg_pkg::REG_ENABLE][i]) &
             (nshift_r[0] | regs_r[psg_pkg::REG_ENABLE][3 + i]);
      out_nxt[6*i +: 5] = !gate ? 5'd0 : (vol[4] ? env_vol : {1'b0, vol[3:0]});
      out_nxt[6*i + 5]  = vol[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        regs_r[i] <= 8'd0;
      end
      addr_valid_r <= 1'b0;
      sel_idx_r    <= 4'd0;
      for (int i = 0; i < psg_pkg::NUM_CH; i++) begin
        tcnt_r[i]   <= 12'd0;
        tphase_r[i] <= 5'd0;
      end
      ncnt_r     <= 5'd0;
      npre_r     <= 1'b0;
      nshift_r   <= 17'd1;
      ecnt_r     <= 16'd0;
      estep_r    <= psg_pkg::ENV_TOP;
      eattack_r  <= 1'b0;
      ehold_r    <= 1'b1;
      ealt_r     <= 1'b0;
      eholding_r <= 1'b0;
      nz1_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        nz1_r <= cfg_wr_data;
      end
      if (cmd.wr_en) begin
        if (in_mode == psg_pkg::MODE_ADDR) begin
          addr_valid_r <= (in_value[7:4] == 4'd0);
          if (in_value[7:4] == 4'd0) begin
            sel_idx_r <= in_value[3:0];
          end
        end else if (in_mode == psg_pkg::MODE_DATA && addr_valid_r) begin
          regs_r[sel_idx_r] <= in_value;
          if (sel_idx_r == psg_pkg::REG_SHAPE) begin
            eattack_r  <= in_value[2];
            eholding_r <= 1'b0;
            estep_r    <= psg_pkg::ENV_TOP;
            if (!in_value[3]) begin
              ehold_r <= 1'b1;
              ealt_r  <= in_value[2];
            end else begin
              ehold_r <= in_value[0];
              ealt_r  <= in_value[1];
            end
          end
        end
      end
      if (cmd.tone_start && !stat.div_needed) begin
        tcnt_r[cmd.ch] <= c_inc[11:0];
      end
      if (cmd.tone_done) begin
        tcnt_r[cmd.ch]   <= rem_r;
        tphase_r[cmd.ch] <= tphase_r[cmd.ch] - quo_r;
      end
      if (cmd.ne_step) begin
        if (nc >= {1'b0, nper}) begin
          ncnt_r <= 5'd0;
          npre_r <= ~npre_r;
          if (npre_r) begin
            nshift_r <= {nshift_r[0] ^ nshift_r[3], nshift_r[16:1]};
          end
        end else begin
          ncnt_r <= nc[4:0];
        end
        if (!eholding_r) begin
          if (ec < {1'b0, eper}) begin
            ecnt_r <= ec[15:0];
          end else begin
            ecnt_r <= 16'd0;
            if (estep_r != 5'd0) begin
              estep_r <= estep_r - 5'd1;
            end else begin
              if (ealt_r) begin
                eattack_r <= ~eattack_r;
              end
              if (ehold_r) begin
                eholding_r <= 1'b1;
              end else begin
                estep_r <= psg_pkg::ENV_TOP;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tone_start) begin
      dvd_r <= c_inc;
      rem_r <= 12'd0;
      quo_r <= 5'd0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[11:0], 1'b0};
      rem_r <= ge ? 12'(r2 - {1'b0, period}) : r2[11:0];
      quo_r <= {quo_r[3:0], ge};
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/psg_ctrl.sv
module psg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_mode,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  psg_pkg::psg_stat_t stat,
  output psg_pkg::psg_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_TLOAD, S_DIV, S_TFIN, S_NE, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd            = '0;
    cmd.ch         = ch_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == psg_pkg::MODE_TICK) begin
            state_nxt = S_TLOAD;
            ch_nxt    = 2'd0;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_TLOAD: begin
        cmd.tone_start = 1'b1;
        bit_nxt        = 4'(psg_pkg::DIV_BITS - 1);
        if (stat.div_needed) begin
          state_nxt = S_DIV;
        end else if (ch_r == 2'(psg_pkg::NUM_CH - 1)) begin
          state_nxt = S_NE;
        end else begin
          ch_nxt = ch_r + 2'd1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r - 4'd1;
        if (bit_r == 4'd0) begin
          state_nxt = S_TFIN;
        end
      end
      S_TFIN: begin
        cmd.tone_done = 1'b1;
        if (ch_r == 2'(psg_pkg::NUM_CH - 1)) begin
          state_nxt = S_NE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_TLOAD;
        end
      end
      S_NE: begin
        cmd.ne_step = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 2'd0;
      bit_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == psg_pkg::MODE_TICK |=> state_r == S_TLOAD)
    else $error("tick did not start tone pass");
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && bit_r == 4'd0 |=> state_r == S_TFIN)
    else $error("division did not end");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten");
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> ch_r != 2'd3)
    else $error("bad channel");
`endif

endmodule
